### design/lpr_pkg.sv
// Shared types and defaults for the line pixel rasterizer.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package lpr_pkg;

   localparam int COORD_BITS_DEF = 6;
   localparam int COLOR_BITS_DEF = 24;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EMIT
   } lpr_state_type;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_STRAIGHT,
      MODE_DIAG_X,
      MODE_DIAG_Y
   } draw_mode_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic advance;
   } lpr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic zero_len;
      logic last;
   } lpr_status_type;

endpackage

### design/lpr_ctrl.sv
// Controller state machine of the line pixel rasterizer.
// Depends on lpr_pkg; drives the handshakes and commands the datapath.
`timescale 1ns / 1ps

module lpr_ctrl
   import lpr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  lpr_status_type status,
   output lpr_cmd_type    cmd
);

   lpr_state_type state_ff;
   lpr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // a zero-length line is taken and dropped
            if (req_valid && !status.zero_len) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready && status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.load    = 1'b0;
      cmd.advance = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_EMIT: begin
            rsp_valid   = 1'b1;
            cmd.advance = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

### design/lpr_dp.sv
// Datapath of the line pixel rasterizer: line setup, position stepping and
// the integer error accumulator. Depends on lpr_pkg; commanded by lpr_ctrl.
`timescale 1ns / 1ps

module lpr_dp
   import lpr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int COLOR_BITS = COLOR_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lpr_cmd_type           cmd,
   output lpr_status_type        status,
   input  logic [COORD_BITS-1:0] req_x0,
   input  logic [COORD_BITS-1:0] req_y0,
   input  logic [COORD_BITS-1:0] req_x1,
   input  logic [COORD_BITS-1:0] req_y1,
   input  logic [COLOR_BITS-1:0] req_color,
   output logic [COORD_BITS-1:0] rsp_px,
   output logic [COORD_BITS-1:0] rsp_py,
   output logic [COLOR_BITS-1:0] rsp_pixel_color,
   output logic                  rsp_last
);

   localparam int CW = COORD_BITS;
   localparam int DW = COORD_BITS + 1;
   localparam int EW = COORD_BITS + 2;

   // stepping state
   draw_mode_type          draw_mode_ff, draw_mode_in;
   logic [CW-1:0]          major_pos_ff, major_pos_in;
   logic [CW-1:0]          minor_pos_ff, minor_pos_in;
   logic                   step_dir_ff, step_dir_in;
   logic signed [EW-1:0]   error_acc_ff, error_acc_in;
   logic signed [DW-1:0]   minor_delta_ff, minor_delta_in;
   logic [CW-1:0]          major_len_ff, major_len_in;
   logic [CW-1:0]          steps_left_ff, steps_left_in;
   logic [COLOR_BITS-1:0]  held_color_ff, held_color_in;
   logic                   axis_y_ff, axis_y_in;

   // setup terms
   logic signed [DW-1:0]   dx, dy;
   logic [CW-1:0]          adx, ady;
   logic                   along_y, straight, xmaj;
   logic [CW-1:0]          ld_major, ld_minor, ld_len;
   logic signed [DW-1:0]   ld_delta;
   logic                   ld_dir, ld_axis_y;
   draw_mode_type          ld_mode;

   // step terms
   logic signed [EW-1:0]   err_sum;
   logic signed [EW-1:0]   len_s;

   assign dx = $signed({1'b0, req_x1}) - $signed({1'b0, req_x0});
   assign dy = $signed({1'b0, req_y1}) - $signed({1'b0, req_y0});
   assign adx = dx[DW-1] ? CW'(-dx) : CW'(dx);
   assign ady = dy[DW-1] ? CW'(-dy) : CW'(dy);
   assign along_y  = (dx == '0);
   assign straight = (dx == '0) || (dy == '0);
   assign xmaj     = (adx >= ady);

   always_comb begin
      ld_major  = req_x0;
      ld_minor  = req_y0;
      ld_len    = adx;
      ld_delta  = '0;
      ld_dir    = 1'b0;
      ld_axis_y = 1'b0;
      ld_mode   = MODE_STRAIGHT;
      priority if (straight) begin
         ld_axis_y = along_y;
         ld_major  = along_y ? req_y0 : req_x0;
         ld_minor  = along_y ? req_x0 : req_y0;
         ld_len    = along_y ? ady : adx;
         ld_dir    = along_y ? dy[DW-1] : dx[DW-1];
         ld_mode   = MODE_STRAIGHT;
      end else if (xmaj) begin
         // order the endpoints so that x increases
         ld_mode = MODE_DIAG_X;
         ld_len  = adx;
         if (!dx[DW-1]) begin
            ld_major = req_x0 + CW'(1);
            ld_minor = req_y0;
            ld_delta = dy;
         end else begin
            ld_major = req_x1 + CW'(1);
            ld_minor = req_y1;
            ld_delta = -dy;
         end
         ld_dir = ld_delta[DW-1];
      end else begin
         ld_mode   = MODE_DIAG_Y;
         ld_axis_y = 1'b1;
         ld_len    = ady;
         if (!dy[DW-1]) begin
            ld_major = req_y0 + CW'(1);
            ld_minor = req_x0;
            ld_delta = dx;
         end else begin
            ld_major = req_y1 + CW'(1);
            ld_minor = req_x1;
            ld_delta = -dx;
         end
         ld_dir = ld_delta[DW-1];
      end
   end

   assign err_sum = error_acc_ff + EW'(minor_delta_ff);
   assign len_s   = $signed({2'b00, major_len_ff});

   always_comb begin
      draw_mode_in   = draw_mode_ff;
      major_pos_in   = major_pos_ff;
      minor_pos_in   = minor_pos_ff;
      step_dir_in    = step_dir_ff;
      error_acc_in   = error_acc_ff;
      minor_delta_in = minor_delta_ff;
      major_len_in   = major_len_ff;
      steps_left_in  = steps_left_ff;
      held_color_in  = held_color_ff;
      axis_y_in      = axis_y_ff;
      priority if (cmd.load) begin
         draw_mode_in   = status.zero_len ? MODE_IDLE : ld_mode;
         major_pos_in   = ld_major;
         minor_pos_in   = ld_minor;
         step_dir_in    = ld_dir;
         error_acc_in   = '0;
         minor_delta_in = ld_delta;
         major_len_in   = ld_len;
         steps_left_in  = ld_len - CW'(1);
         held_color_in  = req_color;
         axis_y_in      = ld_axis_y;
      end else if (cmd.advance) begin
         steps_left_in = steps_left_ff - CW'(1);
         if (status.last) begin
            draw_mode_in = MODE_IDLE;
         end
         if (draw_mode_ff == MODE_STRAIGHT) begin
            major_pos_in = step_dir_ff ? major_pos_ff - CW'(1) : major_pos_ff + CW'(1);
         end else begin
            major_pos_in = major_pos_ff + CW'(1);
            // one correction keeps the remainder in [0, n) since |delta| <= n
            if (step_dir_ff) begin
               if (err_sum < 0) begin
                  error_acc_in = err_sum + len_s;
                  minor_pos_in = minor_pos_ff - CW'(1);
               end else begin
                  error_acc_in = err_sum;
               end
            end else begin
               if (err_sum >= len_s) begin
                  error_acc_in = err_sum - len_s;
                  minor_pos_in = minor_pos_ff + CW'(1);
               end else begin
                  error_acc_in = err_sum;
               end
            end
         end
      end else begin
         draw_mode_in = draw_mode_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_mode_ff <= MODE_IDLE;
      end else begin
         draw_mode_ff <= draw_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      major_pos_ff   <= major_pos_in;
      minor_pos_ff   <= minor_pos_in;
      step_dir_ff    <= step_dir_in;
      error_acc_ff   <= error_acc_in;
      minor_delta_ff <= minor_delta_in;
      major_len_ff   <= major_len_in;
      steps_left_ff  <= steps_left_in;
      held_color_ff  <= held_color_in;
      axis_y_ff      <= axis_y_in;
   end

   assign status.zero_len = (dx == '0) && (dy == '0);
   assign status.last     = (steps_left_ff == '0);

   assign rsp_px          = axis_y_ff ? minor_pos_ff : major_pos_ff;
   assign rsp_py          = axis_y_ff ? major_pos_ff : minor_pos_ff;
   assign rsp_pixel_color = held_color_ff;
   assign rsp_last        = status.last;

endmodule

### design/line_pixel_rasterizer_top.sv
// Line pixel rasterizer: a line segment in, one pixel per cycle out. A segment
// is taken while the block is idle; its n pixels then leave one per cycle from
// the datapath registers while rsp_ready is high, and a zero-length line gives
// no pixel. The single-step datapath makes one position step and one
// error-accumulator add and correction per pixel, and the next segment is taken
// only after the last pixel of the current one has been taken.
// Depends on lpr_pkg, lpr_ctrl and lpr_dp.
`timescale 1ns / 1ps

module line_pixel_rasterizer_top
   import lpr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int COLOR_BITS = COLOR_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_x0,
   input  logic [COORD_BITS-1:0] req_y0,
   input  logic [COORD_BITS-1:0] req_x1,
   input  logic [COORD_BITS-1:0] req_y1,
   input  logic [COLOR_BITS-1:0] req_color,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_px,
   output logic [COORD_BITS-1:0] rsp_py,
   output logic [COLOR_BITS-1:0] rsp_pixel_color,
   output logic                  rsp_last
);

   lpr_cmd_type    cmd;
   lpr_status_type status;

   lpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lpr_dp #(
      .COORD_BITS (COORD_BITS),
      .COLOR_BITS (COLOR_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_x0          (req_x0),
      .req_y0          (req_y0),
      .req_x1          (req_x1),
      .req_y1          (req_y1),
      .req_color       (req_color),
      .rsp_px          (rsp_px),
      .rsp_py          (rsp_py),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last)
   );

endmodule

### design/lpr_checker.sv
// Port-level checks for the line pixel rasterizer, bound to the top level.
// Depends on lpr_pkg for parameter defaults.
`timescale 1ns / 1ps

module lpr_checker
   import lpr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int COLOR_BITS = COLOR_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic [COORD_BITS-1:0] req_x0,
   input logic [COORD_BITS-1:0] req_y0,
   input logic [COORD_BITS-1:0] req_x1,
   input logic [COORD_BITS-1:0] req_y1,
   input logic [COLOR_BITS-1:0] req_color,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COORD_BITS-1:0] rsp_px,
   input logic [COORD_BITS-1:0] rsp_py,
   input logic [COLOR_BITS-1:0] rsp_pixel_color,
   input logic                  rsp_last
);

   // stalled pixel holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_px) && $stable(rsp_py)
         && $stable(rsp_pixel_color) && $stable(rsp_last))
      else $error("stalled pixel changed");

   // one line at a time: no new segment while pixels are pending
   a_one_line: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("segment taken while a line is being drawn");

   // pixels of one line follow without a gap
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside a line");

   // after the last pixel the block is free again
   a_free_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready && !rsp_valid)
      else $error("block not idle after last pixel");

   // a zero-length segment gives no pixel
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_x0 == req_x1 && req_y0 == req_y1
         |=> !rsp_valid && req_ready)
      else $error("zero-length segment produced a pixel");

endmodule

bind line_pixel_rasterizer_top lpr_checker #(
   .COORD_BITS (COORD_BITS),
   .COLOR_BITS (COLOR_BITS)
) u_lpr_checker (.*);
